@@ design/cti_pkg.sv @@
`timescale 1ns / 1ps

package cti_pkg;

    localparam int unsigned DW = 24;        // moisture, depth and divisor width
    localparam int unsigned QW = 2 * DW;    // product / quotient width
    localparam int unsigned SW = QW + 2;    // signed sum width for the final add

    localparam logic [1:0] OUT_INTERP   = 2'd0;
    localparam logic [1:0] OUT_EXACT    = 2'd1;
    localparam logic [1:0] OUT_NO_TABLE = 2'd2;
    localparam logic [1:0] OUT_SAT      = 2'd3;

    localparam logic        CMD_WRITE = 1'b0;
    localparam logic        CMD_EVAL  = 1'b1;

    localparam logic [DW-1:0] NO_TABLE_DEPTH = DW'(999 * 256);
    localparam logic [DW-1:0] DEPTH_MAX      = 24'h7FFFFF;
    localparam logic [DW-1:0] DEPTH_MIN      = 24'h800000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MUL,
        ST_DIV
    } t_state;

    // one stage of the restoring divider chain
    typedef struct packed {
        logic          valid;
        logic [DW-1:0] rem;
        logic [QW-1:0] word;   // dividend bits shift out the top, quotient bits in the bottom
        logic [DW-1:0] den;
    } t_div_stage;

endpackage

@@ design/cti_div_cell.sv @@
`timescale 1ns / 1ps

module cti_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cti_pkg::t_div_stage i_stage,
    output cti_pkg::t_div_stage o_stage
);

    logic [cti_pkg::DW:0]   trial;
    logic [cti_pkg::DW:0]   diff;
    logic                   ge;
    cti_pkg::t_div_stage    n_stage;
    cti_pkg::t_div_stage    r_stage;

    always_comb begin
        trial = {i_stage.rem, i_stage.word[cti_pkg::QW-1]};
        diff  = trial - {1'b0, i_stage.den};
        ge    = (trial >= {1'b0, i_stage.den});
        n_stage.valid = i_stage.valid;
        n_stage.rem   = ge ? diff[cti_pkg::DW-1:0] : trial[cti_pkg::DW-1:0];
        n_stage.word  = {i_stage.word[cti_pkg::QW-2:0], ge};
        n_stage.den   = i_stage.den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.rem  <= n_stage.rem;
        r_stage.word <= n_stage.word;
        r_stage.den  <= n_stage.den;
    end

    assign o_stage = r_stage;

endmodule

@@ design/cti_div_chain.sv @@
`timescale 1ns / 1ps

module cti_div_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cti_pkg::t_div_stage i_stage,
    output cti_pkg::t_div_stage o_stage
);

    cti_pkg::t_div_stage w_link [0:cti_pkg::QW];

    assign w_link[0] = i_stage;

    for (genvar g = 0; g < cti_pkg::QW; g++) begin : g_cell
        cti_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_link[g]),
            .o_stage (w_link[g+1])
        );
    end

    assign o_stage = w_link[cti_pkg::QW];

endmodule

@@ design/curve_table_interpolator_unit.sv @@
`timescale 1ns / 1ps

// Piecewise linear curve lookup. A write (cmd 0) gives no result. An evaluate
// scans its curve from the last point down, one read state and one check state
// per point visited through the single read port of the point memory, then a
// multiply step and a 48-cell restoring divider chain; an evaluate of a curve
// out of range gives a saturated zero result without a scan and without busy.
// The result appears on o_strobe for one cycle only and cannot be stalled;
// busy drops in that same cycle.
module curve_table_interpolator_unit #(
    parameter int unsigned CURVES = 8,
    parameter int unsigned POINTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [2:0]  i_curve_select,
    input  logic [4:0]  i_point_select,
    input  logic [23:0] i_point_moisture,
    input  logic signed [23:0] i_point_depth,
    input  logic [23:0] i_moisture,
    output logic        o_strobe,
    output logic signed [23:0] o_table_depth,
    output logic [1:0]  o_outcome
);

    localparam int unsigned DEPTH = CURVES * POINTS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned IW    = $clog2(POINTS);
    localparam int unsigned DW    = cti_pkg::DW;
    localparam int unsigned QW    = cti_pkg::QW;
    localparam int unsigned SW    = cti_pkg::SW;

    logic [DW-1:0] r_mem_m [0:DEPTH-1];
    logic [DW-1:0] r_mem_d [0:DEPTH-1];
    logic [DW-1:0] r_rd_m, r_rd_d;

    cti_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_addr, n_addr;
    logic [IW-1:0]   r_idx, n_idx;
    logic [DW-1:0]   r_moist, n_moist;
    logic [DW-1:0]   r_mn, n_mn;
    logic [DW-1:0]   r_dn, n_dn;
    logic [DW-1:0]   r_mag, n_mag;
    logic [DW-1:0]   r_delta, n_delta;
    logic [DW-1:0]   r_den, n_den;
    logic            r_neg, n_neg;
    logic            r_strobe, n_strobe;
    logic [DW-1:0]   r_depth, n_depth;
    logic [1:0]      r_outcome, n_outcome;
    logic            r_mul_go, n_mul_go;
    logic [QW-1:0]   r_prod;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            curve_ok;
    logic            point_ok;
    logic signed [DW:0] ddiff;
    logic [SW-1:0]   sum;

    cti_pkg::t_div_stage w_div_in, w_div_out;

    assign curve_ok = (int'(i_curve_select) < CURVES);
    assign point_ok = (int'(i_point_select) < POINTS);
    assign wr_en    = (r_state == cti_pkg::ST_IDLE) && start && (i_cmd == cti_pkg::CMD_WRITE)
                      && curve_ok && point_ok;
    assign wr_addr  = AW'(int'(i_curve_select) * POINTS + int'(i_point_select));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_m[wr_addr] <= i_point_moisture;
            r_mem_d[wr_addr] <= i_point_depth;
        end
        r_rd_m <= r_mem_m[r_addr];
        r_rd_d <= r_mem_d[r_addr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= QW'(r_mag) * QW'(r_delta);
    end

    assign w_div_in.valid = r_mul_go;
    assign w_div_in.rem   = '0;
    assign w_div_in.word  = r_prod;
    assign w_div_in.den   = r_den;

    cti_div_chain u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_div_in),
        .o_stage (w_div_out)
    );

    assign ddiff = $signed({r_rd_d[DW-1], r_rd_d}) - $signed({r_dn[DW-1], r_dn});
    // lower-moisture depth plus or minus the quotient
    assign sum = r_neg ? (SW'($signed(r_dn)) - {2'b00, w_div_out.word})
                       : (SW'($signed(r_dn)) + {2'b00, w_div_out.word});

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_idx     = r_idx;
        n_moist   = r_moist;
        n_mn      = r_mn;
        n_dn      = r_dn;
        n_mag     = r_mag;
        n_delta   = r_delta;
        n_den     = r_den;
        n_neg     = r_neg;
        n_strobe  = 1'b0;
        n_depth   = r_depth;
        n_outcome = r_outcome;
        n_mul_go  = 1'b0;
        unique case (r_state)
            cti_pkg::ST_IDLE: begin
                if (start && i_cmd == cti_pkg::CMD_EVAL) begin
                    if (!curve_ok) begin
                        n_strobe  = 1'b1;
                        n_depth   = '0;
                        n_outcome = cti_pkg::OUT_SAT;
                    end else begin
                        n_moist = i_moisture;
                        n_idx   = IW'(POINTS - 1);
                        n_addr  = AW'(int'(i_curve_select) * POINTS + int'(POINTS - 1));
                        n_state = cti_pkg::ST_READ;
                    end
                end
            end
            cti_pkg::ST_READ: begin
                n_state = cti_pkg::ST_CHECK;
            end
            cti_pkg::ST_CHECK: begin
                if (r_moist > r_rd_m && r_idx != '0) begin
                    n_mn    = r_rd_m;
                    n_dn    = r_rd_d;
                    n_idx   = r_idx - 1'b1;
                    n_addr  = r_addr - 1'b1;
                    n_state = cti_pkg::ST_READ;
                end else if (r_idx == IW'(POINTS - 1)) begin
                    n_strobe = 1'b1;
                    n_state  = cti_pkg::ST_IDLE;
                    if (r_moist < r_rd_m) begin
                        n_depth   = cti_pkg::NO_TABLE_DEPTH;
                        n_outcome = cti_pkg::OUT_NO_TABLE;
                    end else begin
                        n_depth   = r_rd_d;
                        n_outcome = cti_pkg::OUT_EXACT;
                    end
                end else if (r_rd_m <= r_mn) begin
                    n_strobe  = 1'b1;
                    n_depth   = '0;
                    n_outcome = cti_pkg::OUT_SAT;
                    n_state   = cti_pkg::ST_IDLE;
                end else begin
                    n_neg   = ddiff[DW];
                    n_mag   = ddiff[DW] ? DW'(-ddiff) : ddiff[DW-1:0];
                    n_delta = r_moist - r_mn;
                    n_den   = r_rd_m - r_mn;
                    n_state = cti_pkg::ST_MUL;
                end
            end
            cti_pkg::ST_MUL: begin
                n_mul_go = 1'b1;
                n_state  = cti_pkg::ST_DIV;
            end
            cti_pkg::ST_DIV: begin
                if (w_div_out.valid) begin
                    n_strobe = 1'b1;
                    n_state  = cti_pkg::ST_IDLE;
                    if ($signed(sum) > $signed(SW'($signed(cti_pkg::DEPTH_MAX)))) begin
                        n_depth   = cti_pkg::DEPTH_MAX;
                        n_outcome = cti_pkg::OUT_SAT;
                    end else if ($signed(sum) < $signed(SW'($signed(cti_pkg::DEPTH_MIN)))) begin
                        n_depth   = cti_pkg::DEPTH_MIN;
                        n_outcome = cti_pkg::OUT_SAT;
                    end else begin
                        n_depth   = sum[DW-1:0];
                        n_outcome = cti_pkg::OUT_INTERP;
                    end
                end
            end
            default: begin
                n_state = cti_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cti_pkg::ST_IDLE;
            r_strobe <= 1'b0;
            r_mul_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_mul_go <= n_mul_go;
        end
        r_addr    <= n_addr;
        r_idx     <= n_idx;
        r_moist   <= n_moist;
        r_mn      <= n_mn;
        r_dn      <= n_dn;
        r_mag     <= n_mag;
        r_delta   <= n_delta;
        r_den     <= n_den;
        r_neg     <= n_neg;
        r_depth   <= n_depth;
        r_outcome <= n_outcome;
    end

    assign busy          = (r_state != cti_pkg::ST_IDLE);
    assign o_strobe      = r_strobe;
    assign o_table_depth = r_depth;
    assign o_outcome     = r_outcome;

endmodule

@@ test/curve_table_interpolator_unit_tb.sv @@
`timescale 1ns / 1ps

module curve_table_interpolator_unit_tb;

    localparam int unsigned NC = 8;
    localparam int unsigned NP = 32;
    localparam int unsigned TAIL = 2 * NP + 60;

    typedef struct {
        logic        cmd;
        logic [2:0]  curve;
        logic [4:0]  point;
        logic [23:0] pmoist;
        logic [23:0] pdepth;
        logic [23:0] moist;
    } t_item;

    typedef struct {
        logic [23:0] depth;
        logic [1:0]  outcome;
    } t_lookup;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cmd = 1'b0;
    logic [2:0]  i_curve_select = '0;
    logic [4:0]  i_point_select = '0;
    logic [23:0] i_point_moisture = '0;
    logic signed [23:0] i_point_depth = '0;
    logic [23:0] i_moisture = '0;
    logic        o_strobe;
    logic signed [23:0] o_table_depth;
    logic [1:0]  o_outcome;

    curve_table_interpolator_unit #(.CURVES(NC), .POINTS(NP)) i_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of the point memory
    logic [23:0] moist_mem [NC*NP];
    logic [23:0] depth_mem [NC*NP];

    t_item   pending_q[$];
    t_lookup lookup_q[$];
    int      idle_pct = 10;
    bit      hold_off = 1'b0;
    bit      in_flight = 1'b0;
    int      mismatches = 0;
    int      lookups_seen = 0;
    int      writes_sent = 0;

    function automatic t_lookup predict_lookup(t_item it);
        t_lookup r;
        int unsigned b, i;
        logic [23:0] mi, mn;
        longint di, dn, dd, res;
        longint unsigned mag, q;
        b = it.curve * NP;
        if (it.curve >= NC) begin
            r.depth = '0; r.outcome = cti_pkg::OUT_SAT; return r;
        end
        i = NP - 1;
        while (i >= 1 && it.moist > moist_mem[b+i]) i--;
        if (i == NP - 1) begin
            if (it.moist < moist_mem[b+i]) begin
                r.depth = cti_pkg::NO_TABLE_DEPTH; r.outcome = cti_pkg::OUT_NO_TABLE;
            end else begin
                r.depth = depth_mem[b+i]; r.outcome = cti_pkg::OUT_EXACT;
            end
            return r;
        end
        mi = moist_mem[b+i];
        mn = moist_mem[b+i+1];
        if (mi <= mn) begin
            r.depth = '0; r.outcome = cti_pkg::OUT_SAT; return r;
        end
        di = longint'(signed'(depth_mem[b+i]));
        dn = longint'(signed'(depth_mem[b+i+1]));
        dd = di - dn;
        mag = (dd < 0) ? longint'(-dd) : longint'(dd);
        q = (mag * longint'(it.moist - mn)) / longint'(mi - mn);
        res = (dd < 0) ? dn - longint'(q) : dn + longint'(q);
        if (res > 64'sd8388607) begin
            r.depth = cti_pkg::DEPTH_MAX; r.outcome = cti_pkg::OUT_SAT;
        end else if (res < -64'sd8388608) begin
            r.depth = cti_pkg::DEPTH_MIN; r.outcome = cti_pkg::OUT_SAT;
        end else begin
            r.depth = res[23:0]; r.outcome = cti_pkg::OUT_INTERP;
        end
        return r;
    endfunction

    // driver: predicts at the edge where the transfer happens
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                if (i_cmd == cti_pkg::CMD_WRITE) begin
                    moist_mem[i_curve_select*NP + i_point_select] <= i_point_moisture;
                    depth_mem[i_curve_select*NP + i_point_select] <= i_point_depth;
                end else begin
                    lookup_q.push_back(predict_lookup('{i_cmd, i_curve_select,
                        i_point_select, i_point_moisture, i_point_depth, i_moisture}));
                end
            end
            if (!start || !busy) begin
                if (pending_q.size() != 0 && !hold_off &&
                        $urandom_range(99) >= idle_pct) begin
                    t_item it;
                    it = pending_q.pop_front();
                    start            <= 1'b1;
                    i_cmd            <= it.cmd;
                    i_curve_select   <= it.curve;
                    i_point_select   <= it.point;
                    i_point_moisture <= it.pmoist;
                    i_point_depth    <= it.pdepth;
                    i_moisture       <= it.moist;
                    in_flight        <= 1'b1;
                end else begin
                    start     <= 1'b0;
                    in_flight <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            t_lookup e;
            lookups_seen++;
            if (lookup_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result depth=%h outcome=%0d",
                             o_table_depth, o_outcome);
            end else begin
                e = lookup_q.pop_front();
                if (e.depth !== o_table_depth || e.outcome !== o_outcome) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("lookup %0d: exp depth=%h outcome=%0d got depth=%h outcome=%0d",
                                 lookups_seen, e.depth, e.outcome, o_table_depth, o_outcome);
                end
            end
        end
    end

    task automatic add_write(int c, int p, logic [23:0] m, logic [23:0] d);
        pending_q.push_back('{cti_pkg::CMD_WRITE, 3'(c), 5'(p), m, d, 24'($urandom)});
        writes_sent++;
    endtask

    task automatic add_eval(int c, logic [23:0] m);
        pending_q.push_back('{cti_pkg::CMD_EVAL, 3'(c), 5'($urandom), 24'($urandom),
                              24'($urandom), m});
    endtask

    // descending curve with random depths (random moisture when not ordered); steep spacing sometimes
    task automatic load_curve(int c, bit ordered);
        logic [23:0] m;
        int step;
        step = ($urandom_range(3) == 0) ? 1 + $urandom_range(3) : 1 + $urandom_range(500000);
        m = 24'hFFFFFF - 24'($urandom_range(1000));
        for (int p = 0; p < NP; p++) begin
            add_write(c, p, ordered ? m : 24'($urandom), 24'($urandom));
            if (m > step + 2) m = m - 24'($urandom_range(step, 1));
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
        hold_off = 1'b1;
        while (in_flight || start || busy || lookup_q.size() != 0)
            @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    initial begin
        #20_000_000;
        $display("curve_table_interpolator_unit: mismatch");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: fill every curve, then corner lookups
        for (int c = 0; c < NC; c++) load_curve(c, c != 3);
        add_write(0, NP-1, 24'd100, 24'h7FFFFF);
        add_eval(0, 24'd100);
        add_eval(0, 24'd0);
        add_eval(0, 24'd99);
        add_eval(0, 24'hFFFFFF);
        add_eval(3, 24'h800000);
        add_eval(1, 24'hFFFFFF);
        add_write(2, 0, 24'd20, 24'h7FFFFF);
        add_write(2, 1, 24'd10, 24'h800000);
        for (int p = 2; p < NP; p++) add_write(2, p, 24'd10 - 24'(p > 9 ? 9 : p - 1), 24'h800000);
        add_eval(2, 24'hFFFFFF);
        add_write(2, 1, 24'd10, 24'h7FFFFF);
        add_write(2, 0, 24'd11, 24'h800000);
        add_eval(2, 24'hFFFFFF);
        wait_drained();
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 10 : (phase == 1) ? 78 : 0;
            for (int n = 0; n < 460; n++) begin
                int c;
                c = $urandom_range(NC-1);
                if ($urandom_range(99) < 4) begin
                    load_curve(c, $urandom_range(9) != 0);
                    n += NP;
                end else if ($urandom_range(99) < 8) begin
                    add_write(c, $urandom_range(NP-1), 24'($urandom), 24'($urandom));
                end else begin
                    add_eval(c, ($urandom_range(3) == 0) ? 24'($urandom)
                                : 24'hFFFFFF - 24'($urandom_range(20000000)));
                end
            end
            wait_drained();
        end
        repeat (TAIL) @(posedge i_clk);
        $display("covered %0d point writes and %0d curve lookups across three idling mixes",
                 writes_sent, lookups_seen);
        if (mismatches == 0 && lookup_q.size() == 0)
            $display("curve_table_interpolator_unit: match");
        else
            $display("curve_table_interpolator_unit: mismatch");
        $finish;
    end
endmodule
